[hdl/frac_pkg.sv]
// Shared types and constants for the fraction reduction block.
// Depends on nothing; every other file of the block imports it.
package frac_pkg;

  // Width of the numeric fields and of the iteration counters
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DATA_W);

  // One input transfer
  typedef struct packed {
    logic signed [DATA_W-1:0] numerator;
    logic signed [DATA_W-1:0] denominator;
  } frac_in_t;

  // One result transfer
  typedef struct packed {
    logic signed [DATA_W-1:0] reduced_numerator;
    logic signed [DATA_W-1:0] reduced_denominator;
    logic                     both_zero;
  } frac_out_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;        // capture magnitudes and signs of a new fraction
    logic twos_step;   // drop a common factor of two from both operands
    logic strip_step;  // drop a factor of two from operand a
    logic loop_step;   // one step of the binary GCD loop: halve an even b, else subtract
    logic div_start;   // form the divisor and seed both dividers
    logic div_step;    // one restoring division step in both lanes
    logic out_load;    // write the output register
  } frac_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic twos_go;     // both operands nonzero and even
    logic strip_go;    // b nonzero and a even
    logic loop_go;     // b nonzero
    logic div_last;    // final division step
  } frac_sts_t;

endpackage

[hdl/frac_dp.sv]
// Datapath of the fraction reduction block: binary GCD registers and two
// restoring divider lanes. Depends on frac_pkg; driven by frac_ctrl.
module frac_dp (
  input  logic                clk,
  input  frac_pkg::frac_in_t  in_data,
  input  frac_pkg::frac_cmd_t cmd,
  output frac_pkg::frac_sts_t sts,
  output frac_pkg::frac_out_t out_data
);
  import frac_pkg::*;

  logic [DATA_W-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              nneg_r, nneg_nxt, dneg_r, dneg_nxt, bz_r, bz_nxt;
  logic [DATA_W-1:0] div_r, div_nxt;
  logic [DATA_W-1:0] nrem_r, nrem_nxt, nquo_r, nquo_nxt;
  logic [DATA_W-1:0] drem_r, drem_nxt, dquo_r, dquo_nxt;
  frac_out_t         out_r, out_nxt;

  logic [DATA_W-1:0] n_u, d_u, nmag, dmag;
  logic              a_gt_b;
  logic [DATA_W-1:0] a_minus_b, b_minus_a;
  logic [DATA_W:0]   ntrial, dtrial;
  logic [DATA_W-1:0] nsig, dsig;

  // Magnitudes of the incoming fraction
  assign n_u  = in_data.numerator;
  assign d_u  = in_data.denominator;
  assign nmag = n_u[DATA_W-1] ? ('0 - n_u) : n_u;
  assign dmag = d_u[DATA_W-1] ? ('0 - d_u) : d_u;

  // Subtract step operands
  assign a_gt_b    = a_r > b_r;
  assign a_minus_b = a_r - b_r;
  assign b_minus_a = b_r - a_r;

  // Trial subtraction of both divider lanes
  assign ntrial = {nrem_r, nquo_r[DATA_W-1]} - {1'b0, div_r};
  assign dtrial = {drem_r, dquo_r[DATA_W-1]} - {1'b0, div_r};

  // Signed quotients
  assign nsig = nneg_r ? ('0 - nquo_r) : nquo_r;
  assign dsig = dneg_r ? ('0 - dquo_r) : dquo_r;

  // Status toward the controller
  assign sts.twos_go  = (a_r != '0) && (b_r != '0) && !a_r[0] && !b_r[0];
  assign sts.strip_go = (b_r != '0) && !a_r[0];
  assign sts.loop_go  = (b_r != '0);
  assign sts.div_last = (cnt_r == '0);

  // Next state of the datapath registers
  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    k_nxt    = k_r;
    cnt_nxt  = cnt_r;
    nneg_nxt = nneg_r;
    dneg_nxt = dneg_r;
    bz_nxt   = bz_r;
    div_nxt  = div_r;
    nrem_nxt = nrem_r;
    nquo_nxt = nquo_r;
    drem_nxt = drem_r;
    dquo_nxt = dquo_r;
    out_nxt  = out_r;

    if (cmd.load) begin
      nneg_nxt = n_u[DATA_W-1];
      dneg_nxt = d_u[DATA_W-1];
      bz_nxt   = (nmag == '0) && (dmag == '0);
      k_nxt    = '0;
      nquo_nxt = nmag;
      dquo_nxt = dmag;
      // One operand zero: the other magnitude is the divisor
      if ((nmag == '0) || (dmag == '0)) begin
        a_nxt = nmag | dmag;
        b_nxt = '0;
      end else begin
        a_nxt = nmag;
        b_nxt = dmag;
      end
    end

    if (cmd.twos_step) begin
      a_nxt = a_r >> 1;
      b_nxt = b_r >> 1;
      k_nxt = k_r + 1'b1;
    end

    if (cmd.strip_step) begin
      a_nxt = a_r >> 1;
    end

    // Halve an even b, else replace the pair by min and difference
    if (cmd.loop_step) begin
      if (!b_r[0]) begin
        b_nxt = b_r >> 1;
      end else if (a_gt_b) begin
        a_nxt = b_r;
        b_nxt = a_minus_b;
      end else begin
        b_nxt = b_minus_a;
      end
    end

    if (cmd.div_start) begin
      div_nxt  = a_r << k_r;
      nrem_nxt = '0;
      drem_nxt = '0;
      cnt_nxt  = CNT_W'(DATA_W - 1);
    end

    if (cmd.div_step) begin
      cnt_nxt = cnt_r - 1'b1;
      if (!ntrial[DATA_W]) begin
        nrem_nxt = ntrial[DATA_W-1:0];
        nquo_nxt = {nquo_r[DATA_W-2:0], 1'b1};
      end else begin
        nrem_nxt = {nrem_r[DATA_W-2:0], nquo_r[DATA_W-1]};
        nquo_nxt = {nquo_r[DATA_W-2:0], 1'b0};
      end
      if (!dtrial[DATA_W]) begin
        drem_nxt = dtrial[DATA_W-1:0];
        dquo_nxt = {dquo_r[DATA_W-2:0], 1'b1};
      end else begin
        drem_nxt = {drem_r[DATA_W-2:0], dquo_r[DATA_W-1]};
        dquo_nxt = {dquo_r[DATA_W-2:0], 1'b0};
      end
    end

    // Both zero passes zeros through and raises the flag
    if (cmd.out_load) begin
      out_nxt.reduced_numerator   = bz_r ? '0 : nsig;
      out_nxt.reduced_denominator = bz_r ? '0 : dsig;
      out_nxt.both_zero           = bz_r;
    end
  end

  // Payload registers need no reset
  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    k_r    <= k_nxt;
    cnt_r  <= cnt_nxt;
    nneg_r <= nneg_nxt;
    dneg_r <= dneg_nxt;
    bz_r   <= bz_nxt;
    div_r  <= div_nxt;
    nrem_r <= nrem_nxt;
    nquo_r <= nquo_nxt;
    drem_r <= drem_nxt;
    dquo_r <= dquo_nxt;
    out_r  <= out_nxt;
  end

  assign out_data = out_r;

endmodule

[hdl/frac_ctrl.sv]
// Controller of the fraction reduction block: sequences GCD and division
// steps and owns both handshakes. Depends on frac_pkg; drives frac_dp.
module frac_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  frac_pkg::frac_sts_t sts,
  output frac_pkg::frac_cmd_t cmd
);
  import frac_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_TWOS   = 3'd1;
  localparam logic [2:0] ST_STRIP  = 3'd2;
  localparam logic [2:0] ST_LOOP   = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  // Step through the phases of one fraction
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;

    // Drop the held result once its transfer completes
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_TWOS;
        end
      end
      ST_TWOS: begin
        if (sts.twos_go) begin
          cmd.twos_step = 1'b1;
        end else begin
          state_nxt = ST_STRIP;
        end
      end
      ST_STRIP: begin
        if (sts.strip_go) begin
          cmd.strip_step = 1'b1;
        end else begin
          state_nxt = ST_LOOP;
        end
      end
      ST_LOOP: begin
        if (sts.loop_go) begin
          cmd.loop_step = 1'b1;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Hold until the output register is free
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[hdl/fraction_reduce.sv]
// Top level of the fraction reduction block: joins controller and datapath.
// Depends on frac_pkg, frac_ctrl and frac_dp.
//
//   channel | direction | ports                          | payload
//   --------+-----------+--------------------------------+-------------------
//   input   | in        | in_valid, in_ready, in_data    | frac_pkg::frac_in_t
//   result  | out       | out_valid, out_ready, out_data | frac_pkg::frac_out_t
//
// One fraction is in work at a time. It passes a load, the removal of
// common factors of two, the removal of further factors of two from the
// numerator magnitude, the binary GCD loop of halving and subtract steps,
// a step that seeds the dividers, 32 divider steps and an output write.
// Reset is synchronous and active low; it clears the controller only.
// A new fraction is taken while a finished result still waits in the
// output register; a stalled result holds up only the next one's output write.
module fraction_reduce (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  frac_pkg::frac_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output frac_pkg::frac_out_t out_data
);
  import frac_pkg::*;

  frac_cmd_t cmd;
  frac_sts_t sts;

  // Sequence the phases and both handshakes
  frac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // GCD and division registers
  frac_dp u_dp (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
